### hdl/tdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and constants of the timer deadline queue
// Command and result codes, field widths, and the controller/datapath links.
// ----------------------------------------------------------------------------
package tdq_pkg;

	// number of timer slots by default
	localparam int TQ_TIMERS = 32;
	// most expiry beats one tick may emit
	localparam int MAX_OUT = 32;
	// deciseconds per second
	localparam int DSEC_PER_SEC = 10;

	localparam int CMD_W   = 2;
	localparam int ID_W    = 5;
	localparam int DELAY_W = 20;
	localparam int SEC_W   = 32;
	localparam int KIND_W  = 2;
	// deadline width in deciseconds
	localparam int DL_W    = 36;
	// emit counter width, holds MAX_OUT itself
	localparam int EC_W    = $clog2(MAX_OUT + 1);

	typedef enum logic [CMD_W-1:0] {
		OP_ADD     = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_CANCEL  = 2'd2,
		OP_TICK    = 2'd3
	} tdq_op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REPLY  = 2'd0,
		KIND_EXPIRE = 2'd1,
		KIND_NONE   = 2'd2
	} tdq_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EXEC,
		ST_SCAN,
		ST_DECIDE
	} tdq_state_t;

	// controller to datapath
	typedef struct packed {
		logic cap_in;     // latch the accepted input beat
		logic exec;       // apply add, advance or cancel and load the reply
		logic scan_start; // rewind the table scan
		logic scan_step;  // read one entry and fold it into the best pick
		logic take_best;  // disarm the best pick and hold it as pending
		logic emit_pend;  // load the pending expiry into the output register
		logic emit_last;  // last flag for emit_pend
		logic emit_none;  // load the nothing-expired beat
	} tdq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic scan_done;
		logic best_valid;
		logic pend_valid;
		logic count_last;
		logic out_free;
	} tdq_sts_t;

endpackage

### hdl/tdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl: sequencer of the timer deadline queue
// Accepts one input beat at a time, runs command updates and the repeated
// earliest-deadline scans of a tick, and paces loads of the output register.
// ----------------------------------------------------------------------------
module tdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output tdq_pkg::tdq_cmd_t ctl,
	input  tdq_pkg::tdq_sts_t sts
);
	import tdq_pkg::*;

	tdq_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = sts.is_tick ? ST_SCAN : ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.best_valid && !sts.pend_valid) begin
					state_d = sts.count_last ? ST_DECIDE : ST_SCAN;
				end else if (!sts.best_valid && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.cap_in = in_valid;
			end
			ST_DISPATCH: begin
				ctl.scan_start = sts.is_tick;
			end
			ST_EXEC: begin
				ctl.exec = sts.out_free;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
			end
			ST_DECIDE: begin
				if (sts.best_valid && !sts.pend_valid) begin
					// disarm the pick; rescan unless the beat budget is spent
					ctl.take_best  = 1'b1;
					ctl.scan_start = !sts.count_last;
				end else if (sts.pend_valid) begin
					// pending goes out; last once nothing else follows
					ctl.emit_pend = sts.out_free;
					ctl.emit_last = !sts.best_valid;
				end else begin
					ctl.emit_none = sts.out_free;
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/tdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_datapath: timer table, deadline memory, scan and output register
// Armed flags in flops, deadlines in a one-port-read memory, a sequential
// minimum search over the table and the registered result beat.
// ----------------------------------------------------------------------------
module tdq_datapath #(
	parameter int TIMERS = tdq_pkg::TQ_TIMERS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tdq_pkg::tdq_cmd_t            ctl,
	output tdq_pkg::tdq_sts_t            sts,
	input  logic [tdq_pkg::CMD_W-1:0]    cmd,
	input  logic [tdq_pkg::ID_W-1:0]     timer_id,
	input  logic [tdq_pkg::DELAY_W-1:0]  delay,
	input  logic [tdq_pkg::SEC_W-1:0]    now_seconds,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdq_pkg::KIND_W-1:0]   kind,
	output logic                         ok,
	output logic [tdq_pkg::ID_W-1:0]     expired_id,
	output logic                         wake_needed,
	output logic                         last
);
	import tdq_pkg::*;

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 1);

	// captured command
	tdq_op_t             cmd_q;
	logic [ID_W-1:0]     id_q;
	logic [DELAY_W-1:0]  delay_q;
	// current second in deciseconds
	logic [DL_W-1:0]     nowd_q;
	logic [DL_W-1:0]     now_in_d;

	logic [TIMERS-1:0]   armed_q;
	logic [DL_W-1:0]     dl_mem [TIMERS];

	// scan
	logic [CW-1:0]       rd_idx_q;
	logic [IW-1:0]       rd_addr;
	logic                rd_en;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic [DL_W-1:0]     dl_s1;
	logic                cand;
	logic                best_valid_q;
	logic [IW-1:0]       best_id_q;
	logic [DL_W-1:0]     best_dl_q;
	logic                pend_valid_q;
	logic [IW-1:0]       pend_id_q;
	logic [EC_W-1:0]     emit_cnt_q;

	// command evaluation
	logic                id_ok;
	logic [IW-1:0]       slot;
	logic [DL_W-1:0]     new_dl;
	logic                exec_ok;
	logic                exec_wr;
	logic                exec_wake;

	// output register
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic                ok_q;
	logic [ID_W-1:0]     id_out_q;
	logic                wake_q;
	logic                last_q;
	logic                out_free;

	// now_seconds * 10 as shift and add
	assign now_in_d = {1'b0, now_seconds, 3'b000} + {3'b000, now_seconds, 1'b0};

	// latch the input beat; a tick loads the time base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nowd_q <= '0;
		end else if (ctl.cap_in && tdq_op_t'(cmd) == OP_TICK) begin
			nowd_q <= now_in_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			cmd_q   <= tdq_op_t'(cmd);
			id_q    <= timer_id;
			delay_q <= delay;
		end
	end

	// decode add, advance and cancel
	assign id_ok     = {{(32 - ID_W){1'b0}}, id_q} < TIMERS;
	assign slot      = IW'(id_q);
	assign new_dl    = nowd_q + {{(DL_W - DELAY_W){1'b0}}, delay_q};
	// deadline before the next check reduces to delay below one second
	assign exec_wake = delay_q < DELAY_W'(DSEC_PER_SEC);

	always_comb begin
		exec_ok = 1'b0;
		exec_wr = 1'b0;
		if (id_ok) begin
			case (cmd_q)
				OP_ADD: begin
					exec_ok = !armed_q[slot];
					exec_wr = !armed_q[slot];
				end
				OP_ADVANCE: begin
					exec_ok = armed_q[slot];
					exec_wr = armed_q[slot];
				end
				OP_CANCEL: begin
					exec_ok = armed_q[slot];
				end
				default: ;
			endcase
		end
	end

	// update armed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (ctl.exec && exec_ok) begin
			armed_q[slot] <= (cmd_q != OP_CANCEL);
		end else if (ctl.take_best) begin
			armed_q[best_id_q] <= 1'b0;
		end
	end

	// deadline memory: one write, one registered read
	assign rd_addr = rd_idx_q[IW-1:0];
	assign rd_en   = ctl.scan_step && (rd_idx_q < CW'(TIMERS));

	always_ff @(posedge clk) begin
		if (ctl.exec && exec_wr) begin
			dl_mem[slot] <= new_dl;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			dl_s1  <= dl_mem[rd_addr];
			idx_s1 <= rd_addr;
		end
	end

	// advance the scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (ctl.scan_start) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// keep the earliest expired entry; ascending scan gives ties to the lower id
	assign cand = vld_s1 && armed_q[idx_s1] && (dl_s1 < nowd_q) &&
		(!best_valid_q || (dl_s1 < best_dl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
		end else if (ctl.scan_start || ctl.take_best) begin
			best_valid_q <= 1'b0;
		end else if (cand) begin
			best_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			best_id_q <= idx_s1;
			best_dl_q <= dl_s1;
		end
		if (ctl.take_best) begin
			pend_id_q <= best_id_q;
		end
	end

	// pending expiry and emit count of the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			emit_cnt_q   <= '0;
		end else begin
			if (ctl.cap_in) begin
				pend_valid_q <= 1'b0;
				emit_cnt_q   <= '0;
			end else if (ctl.take_best) begin
				pend_valid_q <= 1'b1;
				emit_cnt_q   <= emit_cnt_q + 1'b1;
			end else if (ctl.emit_pend) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// output register: load wins over drain
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec || ctl.emit_pend || ctl.emit_none) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			kind_q   <= KIND_REPLY;
			ok_q     <= exec_ok;
			id_out_q <= id_q;
			wake_q   <= exec_ok && (cmd_q != OP_CANCEL) && exec_wake;
			last_q   <= 1'b1;
		end else if (ctl.emit_pend) begin
			kind_q   <= KIND_EXPIRE;
			ok_q     <= 1'b1;
			id_out_q <= ID_W'(pend_id_q);
			wake_q   <= 1'b0;
			last_q   <= ctl.emit_last;
		end else if (ctl.emit_none) begin
			kind_q   <= KIND_NONE;
			ok_q     <= 1'b1;
			id_out_q <= '0;
			wake_q   <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign ok          = ok_q;
	assign expired_id  = id_out_q;
	assign wake_needed = wake_q;
	assign last        = last_q;

	// status
	assign sts.is_tick    = (cmd_q == OP_TICK);
	assign sts.scan_done  = (rd_idx_q == CW'(TIMERS)) && !vld_s1;
	assign sts.best_valid = best_valid_q;
	assign sts.pend_valid = pend_valid_q;
	assign sts.count_last = (emit_cnt_q == EC_W'(MAX_OUT - 1));
	assign sts.out_free   = out_free;

endmodule

### hdl/timer_deadline_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue: one-shot timer table with earliest-deadline expiry
// Add, advance and cancel single timers; a tick emits up to MAX_OUT expired
// timers, earliest deadline first, and disarms each.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_ready  cmd, timer_id, delay, now_seconds
//  out      source     out_valid/out_ready  kind, ok, expired_id, wake_needed, last
//
//  A command is captured at accept, then passes the dispatch state and loads its
//  reply into the output register from the exec state; the next beat is taken
//  only after the return to idle. A tick runs one table scan through the single
//  read port of the deadline memory per expired timer, plus one closing scan
//  that is skipped once 32 expiries are out.
//  One input beat is in work at a time; in_ready is high only between beats.
//  A stalled output holds the sequencer before the next result is loaded.
//  Reset clears the armed flags and the time base; deadlines need no clearing.
// ----------------------------------------------------------------------------
module timer_deadline_queue #(
	parameter int TIMERS = tdq_pkg::TQ_TIMERS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tdq_pkg::CMD_W-1:0]    cmd,
	input  logic [tdq_pkg::ID_W-1:0]     timer_id,
	input  logic [tdq_pkg::DELAY_W-1:0]  delay,
	input  logic [tdq_pkg::SEC_W-1:0]    now_seconds,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdq_pkg::KIND_W-1:0]   kind,
	output logic                         ok,
	output logic [tdq_pkg::ID_W-1:0]     expired_id,
	output logic                         wake_needed,
	output logic                         last
);
	import tdq_pkg::*;

	tdq_cmd_t ctl;
	tdq_sts_t sts;

	tdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	tdq_datapath #(
		.TIMERS (TIMERS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.timer_id    (timer_id),
		.delay       (delay),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.ok          (ok),
		.expired_id  (expired_id),
		.wake_needed (wake_needed),
		.last        (last)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the timer deadline queue
// Drives add, advance, cancel and tick beats through the input handshake and
// keeps its own timer table, so every reply and every expiry beat is checked
// field by field in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;
	import tdq_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 1200;
	localparam int ITEM_GOAL   = 210;
	localparam int SHOW_LIMIT  = 30;

	typedef struct packed {
		tdq_kind_t       kind;
		logic            ok;
		logic [ID_W-1:0] id;
		logic            wake;
		logic            last;
	} result_beat_t;

	// Timer table mirror and the queue of result beats it predicts
	class expiry_board;
		logic [SEC_W-1:0] now_sec;
		bit               armed [TQ_TIMERS];
		logic [DL_W-1:0]  due [TQ_TIMERS];
		result_beat_t     waiting [$];
		int               errors;

		function new();
			now_sec = '0;
			foreach (armed[i]) armed[i] = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < SHOW_LIMIT)
				$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// Apply one accepted input beat and queue the beats it causes
		function void note_input(tdq_op_t op, logic [ID_W-1:0] id,
				logic [DELAY_W-1:0] dly, logic [SEC_W-1:0] now);
			result_beat_t     beat;
			result_beat_t     prev;
			bit               have_prev;
			longint unsigned  now_ds;
			longint unsigned  fresh;
			longint unsigned  next_check;
			int               best;
			int               n;
			int               i;
			beat.kind = KIND_REPLY;
			beat.ok   = 1'b0;
			beat.id   = id;
			beat.wake = 1'b0;
			beat.last = 1'b1;
			if (op == OP_TICK) begin
				now_sec = now;
				now_ds = 64'(now_sec);
				now_ds = now_ds * DSEC_PER_SEC;
				n = 0;
				have_prev = 1'b0;
				// pick the earliest expired timer, lower id on a tie, until none left or MAX_OUT are picked
				while (n < MAX_OUT) begin
					best = -1;
					for (i = 0; i < TQ_TIMERS; i++) begin
						if (armed[i] && due[i] < now_ds && (best < 0 || due[i] < due[best]))
							best = i;
					end
					if (best < 0)
						break;
					armed[best] = 1'b0;
					if (have_prev)
						waiting.push_back(prev);
					prev.kind = KIND_EXPIRE;
					prev.ok   = 1'b1;
					prev.id   = ID_W'(best);
					prev.wake = 1'b0;
					prev.last = 1'b0;
					have_prev = 1'b1;
					n++;
				end
				if (have_prev) begin
					prev.last = 1'b1;
					waiting.push_back(prev);
				end else begin
					beat.kind = KIND_NONE;
					beat.ok   = 1'b1;
					beat.id   = '0;
					waiting.push_back(beat);
				end
				return;
			end
			fresh = 64'(now_sec);
			fresh = fresh * DSEC_PER_SEC + 64'(dly);
			next_check = 64'(now_sec);
			next_check = (next_check + 1) * DSEC_PER_SEC;
			if (id < TQ_TIMERS) begin
				case (op)
					OP_ADD: begin
						if (!armed[id]) begin
							due[id]   = fresh[DL_W-1:0];
							armed[id] = 1'b1;
							beat.ok   = 1'b1;
							beat.wake = (fresh[DL_W-1:0] < next_check);
						end
					end
					OP_ADVANCE: begin
						if (armed[id]) begin
							due[id]   = fresh[DL_W-1:0];
							beat.ok   = 1'b1;
							beat.wake = (fresh[DL_W-1:0] < next_check);
						end
					end
					default: begin
						if (armed[id]) begin
							armed[id] = 1'b0;
							beat.ok   = 1'b1;
						end
					end
				endcase
			end
			waiting.push_back(beat);
		endfunction

		// Compare one output beat with the oldest prediction
		task check_result(result_beat_t got);
			result_beat_t want;
			if (waiting.size() == 0) begin
				report($sformatf("unexpected beat kind=%0d id=%0d", got.kind, got.id));
				return;
			end
			want = waiting.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.ok !== want.ok)
				report($sformatf("ok %0b, want %0b (id %0d)", got.ok, want.ok, want.id));
			if (got.id !== want.id)
				report($sformatf("expired_id %0d, want %0d", got.id, want.id));
			if (got.wake !== want.wake)
				report($sformatf("wake_needed %0b, want %0b (id %0d)",
					got.wake, want.wake, want.id));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b (id %0d)", got.last, want.last, want.id));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd;
	logic [ID_W-1:0]      timer_id;
	logic [DELAY_W-1:0]   delay;
	logic [SEC_W-1:0]     now_seconds;
	logic                 out_valid;
	logic                 out_ready;
	logic [KIND_W-1:0]    kind;
	logic                 ok;
	logic [ID_W-1:0]      expired_id;
	logic                 wake_needed;
	logic                 last;

	expiry_board board;
	bit          quiet;
	int          sent;

	timer_deadline_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.timer_id    (timer_id),
		.delay       (delay),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.ok          (ok),
		.expired_id  (expired_id),
		.wake_needed (wake_needed),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one input beat, with a random gap ahead of it, and hold it until taken
	task automatic send(tdq_op_t op, int unsigned id, int unsigned dly,
			logic [SEC_W-1:0] now);
		while (!quiet && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		timer_id    <= ID_W'(id);
		delay       <= DELAY_W'(dly);
		now_seconds <= now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_input(op, ID_W'(id), DELAY_W'(dly), now);
		sent++;
	endtask

	// Hold the input side until every predicted beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting.size() != 0)
			@(posedge clk);
	endtask

	// Find a slot that is armed or idle, starting at a random point
	function automatic int find_slot(bit want_armed);
		int start;
		int k;
		int idx;
		start = $urandom_range(0, TQ_TIMERS - 1);
		for (k = 0; k < TQ_TIMERS; k++) begin
			idx = (start + k) % TQ_TIMERS;
			if (board.armed[idx] == want_armed)
				return idx;
		end
		return -1;
	endfunction

	// Take output beats with random backpressure
	initial begin
		result_beat_t got;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind = tdq_kind_t'(kind);
				got.ok   = ok;
				got.id   = expired_id;
				got.wake = wake_needed;
				got.last = last;
				board.check_result(got);
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= 36);
		end
	end

	// End the run when no beat moves on either side for too long
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("[timer_deadline_queue] ERROR");
		$finish;
	end

	initial begin
		int      roll;
		int      slot;
		int      n;
		int      k;
		int      fills;
		bit      drained;
		tdq_op_t op;
		logic [SEC_W-1:0] now;
		board       = new();
		quiet       = 1'b0;
		sent        = 0;
		fills       = 0;
		drained     = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= OP_ADD;
		timer_id    <= '0;
		delay       <= '0;
		now_seconds <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: failures on busy or idle slots, delay extremes, wake edge
		send(OP_TICK, 0, 0, 0);
		send(OP_ADD, 0, 0, 0);
		send(OP_ADD, 0, 5, 0);
		send(OP_ADVANCE, 5, 3, 0);
		send(OP_CANCEL, 5, 0, 0);
		send(OP_ADD, 31, 20'hFFFFF, 32'hFFFFFFFF);
		send(OP_ADVANCE, 31, 9, 0);
		send(OP_ADD, 5, 10, 0);
		send(OP_CANCEL, 5, 0, 0);
		send(OP_ADD, 3, 9, 0);
		send(OP_ADD, 4, 9, 0);
		send(OP_ADD, 2, 20, 0);
		// deadline equal to now stays armed; equal deadlines go out by id
		send(OP_TICK, 0, 0, 0);
		send(OP_TICK, 0, 0, 1);
		send(OP_TICK, 0, 0, 2);
		send(OP_TICK, 0, 0, 3);
		send(OP_ADD, 7, 5, 0);
		send(OP_TICK, 0, 0, 32'hFFFFFFFF);
		send(OP_ADD, 8, 20'hFFFFF, 0);
		// time going backwards
		send(OP_TICK, 0, 0, 1);
		send(OP_ADVANCE, 8, 0, 0);
		send(OP_TICK, 0, 0, 2);
		send(OP_CANCEL, 8, 0, 0);
		drain();

		// random: mostly arm-then-tick sequences, plus noise and misuse
		while (sent < ITEM_GOAL) begin
			quiet = (sent >= 130 && sent < 175);
			if (!drained && sent >= 120) begin
				drain();
				drained = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if ((fills == 0 && sent >= 80) || (roll < 5 && fills < 2)) begin
				// clear the table, arm every slot, expire them all in one tick
				send(OP_TICK, $urandom, $urandom, $urandom_range(0, 100000));
				for (k = 0; k < TQ_TIMERS; k++)
					if (board.armed[k])
						send(OP_CANCEL, k, $urandom, $urandom);
				for (k = 0; k < TQ_TIMERS; k++)
					send(OP_ADD, k, $urandom_range(0, 30), $urandom);
				send(OP_TICK, $urandom, $urandom, board.now_sec + 4);
				fills++;
			end else if (roll < 55) begin
				n = $urandom_range(1, 5);
				repeat (n) begin
					slot = find_slot(1'b0);
					if (slot >= 0)
						send(OP_ADD, slot, $urandom_range(0, 40), $urandom);
				end
				if ($urandom_range(0, 1)) begin
					slot = find_slot(1'b1);
					if (slot >= 0)
						send(OP_ADVANCE, slot, $urandom_range(0, 40), $urandom);
				end
				if ($urandom_range(0, 3) == 0) begin
					slot = find_slot(1'b1);
					if (slot >= 0)
						send(OP_CANCEL, slot, $urandom, $urandom);
				end
				send(OP_TICK, $urandom, $urandom, board.now_sec + $urandom_range(0, 4));
			end else if (roll < 78) begin
				op = tdq_op_t'($urandom_range(0, 3));
				if (op == OP_TICK && $urandom_range(0, 2) != 0)
					now = board.now_sec + $urandom_range(0, 20);
				else
					now = $urandom;
				send(op, $urandom, $urandom, now);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						slot = find_slot(1'b1);
						if (slot >= 0)
							send(OP_ADD, slot, $urandom, $urandom);
					end
					1: begin
						slot = find_slot(1'b0);
						if (slot >= 0)
							send(OP_ADVANCE, slot, $urandom, $urandom);
					end
					2: begin
						slot = find_slot(1'b0);
						if (slot >= 0)
							send(OP_CANCEL, slot, $urandom, $urandom);
					end
					default: begin
						send(OP_TICK, $urandom, $urandom, board.now_sec - $urandom_range(1, 5));
					end
				endcase
			end
		end

		// wind down: wait for the last beats, then watch for strays
		quiet = 1'b0;
		in_valid <= 1'b0;
		while (board.waiting.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0)
			$display("[timer_deadline_queue] OK");
		else
			$display("[timer_deadline_queue] ERROR");
		$finish;
	end

endmodule

### files.f
hdl/tdq_pkg.sv
hdl/tdq_ctrl.sv
hdl/tdq_datapath.sv
hdl/timer_deadline_queue.sv
tb/sv/tb.sv
